// ===== src/wbpr_pkg.sv =====
// Shared types and constants for the wildcard byte pattern replace block.
// No dependencies; every other file of the block but wbpr_checker uses this package.
package wbpr_pkg;

  // Pattern length in bytes, 1 to 8
  localparam int unsigned PatternLen = 8;
  // Window index width and byte count width
  localparam int unsigned IdxW = (PatternLen > 1) ? $clog2(PatternLen) : 1;
  localparam int unsigned CntW = $clog2(PatternLen + 1);
  // Output queue holds two full windows
  localparam int unsigned FifoDepth = 2 * PatternLen;
  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned LevelW = $clog2(FifoDepth + 1);

  // Configuration port
  localparam int unsigned RegW = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [7:0] WildcardByte = 8'h2A;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMatchPattern = 2'd0,
    CfgReplacement  = 2'd1
  } cfg_reg_e;

  typedef logic [PatternLen-1:0][7:0] win_t;

  // Bytes produced by one input item, oldest first in bytes[0]
  typedef struct packed {
    logic [CntW-1:0] count;
    win_t            bytes;
    logic            last;
    logic            found;
  } result_t;

  // One queued output item
  typedef struct packed {
    logic [7:0] byte_out;
    logic       last_out;
    logic       found_any;
  } out_entry_t;

endpackage

// ===== src/wbpr_if.sv =====
// Valid/ready channel interfaces: input bytes, output bytes, register writes.
// Depends on wbpr_pkg for widths.
interface wbpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_in;

  modport source (output valid, output byte_in, output last_in, input ready);
  modport sink   (input valid, input byte_in, input last_in, output ready);
endinterface

interface wbpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       last_out;
  logic       found_any;

  modport source (output valid, output byte_out, output last_out, output found_any,
                  input ready);
  modport sink   (input valid, input byte_out, input last_out, input found_any,
                  output ready);
endinterface

interface wbpr_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [wbpr_pkg::CfgIdxW-1:0] index;
  logic [wbpr_pkg::RegW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/wbpr_window.sv =====
// Sliding byte window with wildcard compare, skip counter and match flag.
// Produces up to PatternLen result bytes per item. Depends on wbpr_pkg.
module wbpr_window (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  logic [7:0]        byte_i,
  input  logic              last_i,
  input  wbpr_pkg::win_t    pattern_i,
  input  wbpr_pkg::win_t    repl_i,
  output wbpr_pkg::result_t result_o
);
  import wbpr_pkg::*;

  win_t            win_q, win_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [IdxW-1:0] skip_q, skip_d;
  logic            seen_q, seen_d;

  win_t            win_a;
  win_t            win_shift;
  logic [CntW-1:0] fill_a;
  logic [CntW-1:0] fill_b;
  logic            full;
  logic            hit;
  logic            matched;
  logic            shift;

  // Insert the new byte behind the valid part of the window
  always_comb begin
    fill_a = (fill_q >= CntW'(PatternLen)) ? CntW'(PatternLen - 1) : fill_q;
    win_a  = win_q;
    win_a[fill_a[IdxW-1:0]] = byte_i;
    fill_b = fill_a + CntW'(1);
    full   = (fill_b == CntW'(PatternLen));
  end

  // Compare all window bytes in parallel; wildcard bytes always match
  always_comb begin
    hit = 1'b1;
    for (int k = 0; k < PatternLen; k++) begin
      if (pattern_i[k] != WildcardByte && pattern_i[k] != win_a[k]) begin
        hit = 1'b0;
      end
    end
    matched = (skip_q == '0) && full && hit;
    shift   = full && !matched;
  end

  // Drop the oldest byte
  always_comb begin
    win_shift = win_a;
    for (int k = 0; k < PatternLen - 1; k++) begin
      win_shift[k] = win_a[k + 1];
    end
  end

  // Result bytes: the replacement on a match, otherwise window contents
  always_comb begin
    result_o.bytes = matched ? repl_i : win_a;
    result_o.last  = last_i;
    result_o.found = seen_q | matched;
    if (matched) begin
      result_o.count = CntW'(PatternLen);
    end else if (shift) begin
      result_o.count = last_i ? CntW'(PatternLen) : CntW'(1);
    end else begin
      result_o.count = last_i ? fill_b : '0;
    end
  end

  // Next window state; the final byte of a stream clears it
  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    skip_d = skip_q;
    seen_d = seen_q;
    if (item_valid_i) begin
      if (last_i) begin
        win_d  = '0;
        fill_d = '0;
        skip_d = '0;
        seen_d = 1'b0;
      end else begin
        if (skip_q != '0) begin
          skip_d = skip_q - IdxW'(1);
        end else if (matched) begin
          skip_d = IdxW'(PatternLen - 1);
        end
        seen_d = seen_q | matched;
        if (matched) begin
          win_d  = win_a;
          fill_d = '0;
        end else if (shift) begin
          win_d  = win_shift;
          fill_d = CntW'(PatternLen - 1);
        end else begin
          win_d  = win_a;
          fill_d = fill_b;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
      skip_q <= '0;
      seen_q <= 1'b0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
      skip_q <= skip_d;
      seen_q <= seen_d;
    end
  end

endmodule

// ===== src/wbpr_out_fifo.sv =====
// Output queue: takes up to PatternLen bytes per cycle, sends one per cycle while out_o.ready is high.
// Depends on wbpr_pkg and the wbpr_out_if interface.
module wbpr_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  wbpr_pkg::result_t wr_data_i,
  output logic              space_ok_o,
  wbpr_out_if.source        out_o
);
  import wbpr_pkg::*;

  out_entry_t        mem_q [FifoDepth];
  logic [PtrW-1:0]   head_q, head_d;
  logic [PtrW-1:0]   tail_q, tail_d;
  logic [LevelW-1:0] level_q, level_d;
  logic [PtrW-1:0]   slot [PatternLen];
  logic              pop;
  logic [CntW-1:0]   push_cnt;

  // Add to a queue pointer with wrap; the sum stays below twice the depth
  function automatic logic [PtrW-1:0] ptr_add(logic [PtrW-1:0] ptr, logic [CntW-1:0] inc);
    logic [PtrW+CntW-1:0] sum;
    sum = (PtrW + CntW)'(ptr) + (PtrW + CntW)'(inc);
    if (sum >= (PtrW + CntW)'(FifoDepth)) begin
      sum = sum - (PtrW + CntW)'(FifoDepth);
    end
    return sum[PtrW-1:0];
  endfunction

  assign pop      = out_o.valid && out_o.ready;
  assign push_cnt = wr_en_i ? wr_data_i.count : '0;

  // Queue slot of each incoming byte
  always_comb begin
    for (int k = 0; k < PatternLen; k++) begin
      slot[k] = ptr_add(tail_q, CntW'(k));
    end
  end

  always_comb begin
    tail_d  = ptr_add(tail_q, push_cnt);
    head_d  = pop ? ptr_add(head_q, CntW'(1)) : head_q;
    level_d = level_q + LevelW'(push_cnt) - LevelW'(pop);
  end

  // Write the new bytes; only the final one may carry last and found
  always_ff @(posedge clk_i) begin
    for (int e = 0; e < FifoDepth; e++) begin
      for (int k = 0; k < PatternLen; k++) begin
        if (wr_en_i && CntW'(k) < wr_data_i.count && slot[k] == PtrW'(e)) begin
          mem_q[e].byte_out  <= wr_data_i.bytes[k];
          mem_q[e].last_out  <= wr_data_i.last &&
                                (CntW'(k) == wr_data_i.count - CntW'(1));
          mem_q[e].found_any <= wr_data_i.last && wr_data_i.found &&
                                (CntW'(k) == wr_data_i.count - CntW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      level_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      level_q <= level_d;
    end
  end

  // Room for one full window of results
  assign space_ok_o      = (level_q <= LevelW'(PatternLen));
  assign out_o.valid     = (level_q != '0);
  assign out_o.byte_out  = mem_q[head_q].byte_out;
  assign out_o.last_out  = mem_q[head_q].last_out;
  assign out_o.found_any = mem_q[head_q].found_any;

endmodule

// ===== src/wildcard_byte_pattern_replace.sv =====
// Top level of the wildcard byte pattern replace block.
// Depends on wbpr_pkg, wbpr_if, wbpr_window and wbpr_out_fifo.
//
// Usage:
//   in_i   carries the data stream one byte per item (byte_in, last_in).
//   out_o  returns the stream with every matching 8-byte window replaced
//          (byte_out, last_out, found_any on the final byte).
//   cfg_i  writes match_pattern (index 0) and replacement_bytes (index 1);
//          other indexes are ignored. Write only while the block is idle.
//          A pattern byte of 0x2A matches any data byte.
// Data path: an accepted byte is held in the input register, enters the window
//   when the queue has room, and is queued once the window releases it (on a
//   match, a shift or the final byte); out_o is fed from the queue.
// Throughput: one byte per cycle while the queue has room. A 16-entry output
//   queue absorbs replacement and end-of-stream flush bursts; in_i.ready drops
//   while a byte is held and over 8 wait, when the receiver stalls long enough.
// Reset clears the window, skip counter, match flag, queue and both
//   registers. After the final byte of a stream the window state returns to
//   zero while the registers keep their values.
module wildcard_byte_pattern_replace (
  input  logic       clk_i,
  input  logic       rst_ni,
  wbpr_cfg_if.sink   cfg_i,
  wbpr_in_if.sink    in_i,
  wbpr_out_if.source out_o
);
  import wbpr_pkg::*;

  logic [RegW-1:0] pattern_q;
  logic [RegW-1:0] repl_q;

  logic            s1_valid_q, s1_valid_d;
  logic [7:0]      s1_byte_q;
  logic            s1_last_q;
  logic            in_acc;
  logic            s1_fire;
  logic            space_ok;
  result_t         result;

  // Register writes are always taken
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      repl_q    <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgMatchPattern: pattern_q <= cfg_i.data;
        CfgReplacement:  repl_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input register: take a new item when empty or when the held one moves on
  assign s1_fire    = s1_valid_q && space_ok;
  assign in_i.ready = !s1_valid_q || space_ok;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_fire) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q <= in_i.byte_in;
      s1_last_q <= in_i.last_in;
    end
  end

  wbpr_window u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (s1_fire),
    .byte_i       (s1_byte_q),
    .last_i       (s1_last_q),
    .pattern_i    (pattern_q[8*PatternLen-1:0]),
    .repl_i       (repl_q[8*PatternLen-1:0]),
    .result_o     (result)
  );

  wbpr_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (s1_fire),
    .wr_data_i  (result),
    .space_ok_o (space_ok),
    .out_o      (out_o)
  );

endmodule

// ===== src/wbpr_checker.sv =====
// Port-level checks for wildcard_byte_pattern_replace, attached by bind.
// Sees only the top level's channel signals; no package dependency.
module wbpr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       out_last_i,
  input logic       out_found_i
);

  // Hold a stalled output item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(out_last_i) && $stable(out_found_i))
    else $error("stalled output item changed");

  // The match flag only rides on the final byte of a stream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !out_found_i)
    else $error("found_any set on a non-final byte");

  // An empty output side comes back only after an accepted byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("output appeared without a matching input item");

  // With nothing queued the input side must be open
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output queue is empty");

endmodule

bind wildcard_byte_pattern_replace wbpr_checker u_wbpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.byte_out),
  .out_last_i  (out_o.last_out),
  .out_found_i (out_o.found_any)
);

// ===== verif/tb_wildcard_byte_pattern_replace.sv =====
// Testbench for wildcard_byte_pattern_replace: streams of bytes against a predictor of the
// windowed search and replace. Depends on wbpr_pkg, the wbpr_if interfaces and the RTL in src.
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_replace;
  import wbpr_pkg::*;

  localparam int HalfPeriod  = 5;
  localparam int ResetCycles = 8;
  localparam int ItemsTarget = 460;
  localparam int QuietTail   = 60;
  localparam int PhaseItems  = 60;
  localparam int DrainCycles = 8;
  localparam int TailCycles  = 16;
  localparam longint TimeoutNs = 5_000_000;

  // Indexes past the register list; the block ignores writes to them
  localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareHi = CfgIdxW'(3);

  // Predicts the output stream from accepted bytes and holds the bytes still owed
  class replace_tracker;
    logic [RegW-1:0] pattern;
    logic [RegW-1:0] replacement;
    logic [7:0]      win [PatternLen];
    logic [CntW-1:0] fill;
    logic [IdxW-1:0] skip;
    logic            seen;
    out_entry_t      expected_q[$];
    int              errors;

    function new();
      pattern     = '0;
      replacement = '0;
      errors      = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (win[k]) win[k] = 8'h00;
      fill = '0;
      skip = '0;
      seen = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] data);
      case (idx)
        CfgMatchPattern: pattern = data;
        CfgReplacement:  replacement = data;
        default: ;
      endcase
    endfunction

    function bit window_hits();
      logic [7:0] p;
      for (int k = 0; k < PatternLen; k++) begin
        p = pattern[8*k +: 8];
        if (p != WildcardByte && p != win[k]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Advance the window by one accepted byte and queue the bytes it releases
    function void note_byte(logic [7:0] b, logic last);
      out_entry_t step_out [2*PatternLen];
      int n;
      n = 0;
      if (fill >= PatternLen) fill = CntW'(PatternLen - 1);
      win[fill] = b;
      fill = fill + 1'b1;

      // Compare only a full window outside the skip span of an earlier match
      if (skip != '0) begin
        skip = skip - 1'b1;
      end else if (fill == PatternLen && window_hits()) begin
        for (int k = 0; k < PatternLen; k++) begin
          step_out[n] = '{replacement[8*k +: 8], 1'b0, 1'b0};
          n++;
        end
        fill = '0;
        seen = 1'b1;
        skip = IdxW'(PatternLen - 1);
      end

      // Shift out the oldest byte of a full window
      if (fill == PatternLen) begin
        step_out[n] = '{win[0], 1'b0, 1'b0};
        n++;
        for (int k = 1; k < PatternLen; k++) win[k-1] = win[k];
        fill = fill - 1'b1;
      end

      // Flush on the final byte and tag the last output
      if (last) begin
        for (int k = 0; k < fill; k++) begin
          step_out[n] = '{win[k], 1'b0, 1'b0};
          n++;
        end
        if (n > 0) begin
          step_out[n-1].last_out  = 1'b1;
          step_out[n-1].found_any = seen;
        end
        clear_stream();
      end

      for (int k = 0; k < n; k++) expected_q.push_back(step_out[k]);
    endfunction

    function void check_byte(logic [7:0] b, logic l, logic f);
      out_entry_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected output item: byte_out %02h last_out %0b found_any %0b", b, l, f);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (b !== want.byte_out) begin
        $error("byte_out: expected %02h, actual %02h", want.byte_out, b);
        errors++;
      end
      if (l !== want.last_out) begin
        $error("last_out: expected %0b, actual %0b", want.last_out, l);
        errors++;
      end
      if (f !== want.found_any) begin
        $error("found_any: expected %0b, actual %0b", want.found_any, f);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  wbpr_in_if  in_if ();
  wbpr_out_if out_if ();
  wbpr_cfg_if cfg_if ();

  wildcard_byte_pattern_replace dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  replace_tracker tracker;
  logic [7:0]     stream_q[$];
  bit             quiet;
  int             items_sent;

  always #(HalfPeriod) clk_i = ~clk_i;

  // Check every output item taken at a rising edge
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      tracker.check_byte(out_if.byte_out, out_if.last_out, out_if.found_any);
    end
  end

  // Stall the output in random bursts, hold ready high in quiet stretches
  initial begin
    int span;
    bit stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (quiet) begin
        @(negedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        stall = ($urandom_range(0, 3) == 0);
        span  = stall ? $urandom_range(1, 17) : $urandom_range(1, 24);
        repeat (span) begin
          @(negedge clk_i);
          out_if.ready <= !stall;
        end
      end
    end
  end

  initial begin
    #(TimeoutNs);
    $display("** wildcard_byte_pattern_replace: FAILED **");
    $finish;
  end

  // Offer one byte, with an optional gap first, and wait for it to be taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.byte_in <= b;
    in_if.last_in <= last;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    tracker.note_byte(b, last);
    items_sent++;
  endtask

  // Drop valid and wait until every owed byte has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    tracker.write_reg(idx, data);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // Pattern byte k with wildcards filled by random data, now and then by the wildcard itself
  function automatic logic [7:0] filled_pattern_byte(int k);
    logic [7:0] p;
    p = tracker.pattern[8*k +: 8];
    if (p != WildcardByte) return p;
    return ($urandom_range(0, 5) == 0) ? WildcardByte : 8'($urandom);
  endfunction

  function automatic logic [RegW-1:0] random_pattern();
    logic [RegW-1:0] r;
    for (int k = 0; k < PatternLen; k++) begin
      r[8*k +: 8] = ($urandom_range(0, 3) == 0) ? WildcardByte : 8'($urandom);
    end
    return r;
  endfunction

  task automatic send_pattern_run(input int count, input bit end_stream);
    for (int k = 0; k < count; k++) send_byte(filled_pattern_byte(k), end_stream && k == count - 1);
  endtask

  // Build a stream of pattern hits, corrupted hits, cut-off prefixes and noise
  function automatic void build_random_stream();
    int target, kind, start, len, pos;
    stream_q.delete();
    target = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : $urandom_range(9, 48);
    while (stream_q.size() < target) begin
      kind  = $urandom_range(0, 9);
      start = stream_q.size();
      if (kind <= 4) begin
        for (int k = 0; k < PatternLen; k++) stream_q.push_back(filled_pattern_byte(k));
        if (kind == 4) begin
          pos = start + $urandom_range(0, PatternLen - 1);
          stream_q[pos] = stream_q[pos] ^ 8'($urandom_range(1, 255));
        end
      end else if (kind <= 6) begin
        len = $urandom_range(1, PatternLen - 1);
        for (int k = 0; k < len; k++) stream_q.push_back(filled_pattern_byte(k));
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          pos = $urandom_range(0, PatternLen - 1);
          stream_q.push_back($urandom_range(0, 1) ? 8'($urandom) : tracker.pattern[8*pos +: 8]);
        end
      end
    end
  endfunction

  task automatic send_stream(input int pause_at);
    for (int i = 0; i < stream_q.size(); i++) begin
      if (i == pause_at && i > 0) wait_drained();
      send_byte(stream_q[i], i == stream_q.size() - 1);
    end
  endtask

  // Load the registers for one phase, extremes first, then random settings
  task automatic configure_phase(input int phase);
    logic [RegW-1:0] pat, rep;
    case (phase)
      0: begin pat = '1; rep = '0; end
      1: begin pat = {PatternLen{WildcardByte}}; rep = '1; end
      2: begin pat = '0; rep = '1; end
      default: begin pat = random_pattern(); rep = {$urandom, $urandom}; end
    endcase
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CfgMatchPattern, pat);
      write_reg(CfgReplacement, rep);
    end else begin
      write_reg(CfgReplacement, rep);
      write_reg(CfgMatchPattern, pat);
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg($urandom_range(0, 1) ? CfgSpareLo : CfgSpareHi, {$urandom, $urandom});
    end
  endtask

  initial begin
    int phase, phase_start, pause_at;
    tracker       = new();
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.byte_in = 8'h00;
    in_if.last_in = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = CfgMatchPattern;
    cfg_if.data   = '0;
    quiet         = 1'b0;
    items_sent    = 0;

    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Zero bytes against the reset registers: a hit followed by one trailing byte
    for (int k = 0; k < PatternLen + 1; k++) send_byte(8'h00, k == PatternLen);
    wait_drained();

    // Fixed pattern with wildcards; spare indexes must leave it alone
    write_reg(CfgMatchPattern, 64'h2A3C_5A2A_F00F_81A5);
    write_reg(CfgReplacement, 64'h0123_4567_89AB_CDEF);
    write_reg(CfgSpareLo, '1);
    write_reg(CfgSpareHi, '1);

    // Hit ending on the final byte, a one-byte stream, a hit cut off by the end
    send_pattern_run(PatternLen, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_pattern_run(PatternLen - 1, 1'b1);
    wait_drained();

    phase = 0;
    while (items_sent < ItemsTarget) begin
      configure_phase(phase);
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems && items_sent < ItemsTarget) begin
        quiet = (items_sent >= ItemsTarget - QuietTail) || ($urandom_range(0, 5) == 0);
        build_random_stream();
        pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(0, stream_q.size() - 1) : -1;
        send_stream(pause_at);
      end
      wait_drained();
      phase++;
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("** wildcard_byte_pattern_replace: PASSED **");
    end else begin
      $display("** wildcard_byte_pattern_replace: FAILED **");
    end
    $finish;
  end

endmodule
